>>> rtl/core/software_timer_bank_macros.svh
// ----------------------------------------------------------------------------
// Timer bank assertion macros
// Shorthand for clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

// same-cycle implication
`define STB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/stb_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Shared constants, opcodes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int OP_W  = 2;
    localparam int ID_W  = 4;
    localparam int DUR_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ORDER,
        S_UPD,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic start;
        logic stop_clear;
        logic pass_init;
        logic stop_step;
        logic count_read;
        logic tick_step;
        logic finish;
    } stb_cmd_t;

    typedef struct packed {
        logic id_ok;
        logic id_running;
        logic total_zero;
        logic pass_done;
        logic expire;
        logic pend_valid;
        logic out_free;
    } stb_sts_t;

endpackage

>>> rtl/core/software_timer_bank.sv
// ----------------------------------------------------------------------------
// Software timer bank
// Countdown timers kept in start order; a tick expires and reports them.
// ----------------------------------------------------------------------------
// Start, unknown op, stop of an idle timer, quiet tick on empty set: no pass.
// Stop of a running timer: a compaction pass over the run-order entries.
// Tick: a pass that can wait on output stall; each entry takes a run-order read
// and a count read-modify-write through single-port-read memories.
// Results trail the tick by one expiry; the last index leaves at pass end.
// Reset clears control and running flags at once; no memory clearing pass.
module software_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [OP_W-1:0]  op,
    input  logic [ID_W-1:0]  timer_id,
    input  logic [DUR_W-1:0] duration,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ID_W-1:0]  expired_id,
    output logic             last
);

    stb_cmd_t cmd;
    stb_sts_t sts;

    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    stb_dp #(
        .NUM_TIMERS (NUM_TIMERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .timer_id   (timer_id),
        .duration   (duration),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .expired_id (expired_id),
        .last       (last),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

>>> rtl/core/stb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/stb_ctrl.sv
// ----------------------------------------------------------------------------
// Timer bank controller
// Accepts items and sequences the run-order passes for tick and stop.
// ----------------------------------------------------------------------------
module stb_ctrl
    import stb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [OP_W-1:0] op,
    input  stb_sts_t        sts,
    output stb_cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;
    logic   tick_mode_reg;
    logic   tick_mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_mode_reg <= tick_mode_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tick_mode_next = tick_mode_reg;
        cmd            = '0;
        in_stall       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (op_t'(op))
                        OP_TICK:
                        begin
                            if (!sts.total_zero)
                            begin
                                cmd.pass_init  = 1'b1;
                                tick_mode_next = 1'b1;
                                state_next     = S_ORDER;
                            end
                        end
                        OP_START:
                        begin
                            cmd.start = 1'b1;
                        end
                        OP_STOP:
                        begin
                            if (sts.id_ok)
                            begin
                                cmd.stop_clear = 1'b1;
                                if (sts.id_running)
                                begin
                                    cmd.pass_init  = 1'b1;
                                    tick_mode_next = 1'b0;
                                    state_next     = S_ORDER;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ORDER:
            begin
                if (sts.pass_done)
                begin
                    state_next = S_FLUSH;
                end
                else if (tick_mode_reg)
                begin
                    cmd.count_read = 1'b1;
                    state_next     = S_UPD;
                end
                else
                begin
                    cmd.stop_step = 1'b1;
                end
            end
            S_UPD:
            begin
                // a second expiry pushes the held one out; wait for room
                if (!(sts.expire && sts.pend_valid && !sts.out_free))
                begin
                    cmd.tick_step = 1'b1;
                    state_next    = S_ORDER;
                end
            end
            S_FLUSH:
            begin
                if (!(sts.pend_valid && !sts.out_free))
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/stb_dp.sv
// ----------------------------------------------------------------------------
// Timer bank datapath
// Count and run-order memories, running flags, pass pointers, output register.
// ----------------------------------------------------------------------------
module stb_dp
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ID_W-1:0]  timer_id,
    input  logic [DUR_W-1:0] duration,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [ID_W-1:0]  expired_id,
    output logic             last,
    input  stb_cmd_t         cmd,
    output stb_sts_t         sts
);

    localparam int IDX_W     = $clog2(NUM_TIMERS);
    localparam int TOT_W     = $clog2(NUM_TIMERS + 1);
    localparam int ID_EXT_W  = (IDX_W > ID_W) ? IDX_W : ID_W;

    logic [ID_EXT_W-1:0]   id_ext;
    logic [IDX_W-1:0]      in_idx;
    logic [COUNT_BITS-1:0] count;
    logic                  id_ok;
    logic                  start_ok;

    logic [NUM_TIMERS-1:0] running_reg;
    logic [NUM_TIMERS-1:0] running_next;
    logic [TOT_W-1:0]      total_reg;
    logic [TOT_W-1:0]      total_next;
    logic [TOT_W-1:0]      k_reg;
    logic [TOT_W-1:0]      k_next;
    logic [TOT_W-1:0]      k_plus;
    logic [TOT_W-1:0]      w_reg;
    logic [TOT_W-1:0]      w_next;
    logic [IDX_W-1:0]      stop_idx_reg;
    logic [IDX_W-1:0]      stop_idx_next;
    logic [IDX_W-1:0]      cur_idx_reg;
    logic [IDX_W-1:0]      cur_idx_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic [IDX_W-1:0]      pend_idx_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ID_W-1:0]       out_id_reg;
    logic [ID_W-1:0]       out_id_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic                  ord_we;
    logic [IDX_W-1:0]      ord_waddr;
    logic [IDX_W-1:0]      ord_wdata;
    logic                  ord_re;
    logic [IDX_W-1:0]      ord_raddr;
    logic [IDX_W-1:0]      ord_rdata;

    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  cnt_re;
    logic [IDX_W-1:0]      cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [COUNT_BITS-1:0] dec;
    logic                  expire;
    logic                  out_free;

    assign id_ext   = ID_EXT_W'(timer_id);
    assign in_idx   = id_ext[IDX_W-1:0];
    assign id_ok    = {1'b0, id_ext} < (ID_EXT_W + 1)'(NUM_TIMERS);
    assign count    = COUNT_BITS'(duration);
    assign start_ok = id_ok && (count != '0);
    assign k_plus   = k_reg + TOT_W'(1);
    assign dec      = cnt_rdata - COUNT_BITS'(1);
    assign expire   = (dec == '0);
    assign out_free = !out_valid_reg || !out_stall;

    // timer indices of the running set, oldest first
    stb_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_TIMERS)
    ) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .re    (ord_re),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // remaining count per timer; only read for running timers
    stb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_TIMERS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_comb
    begin
        running_next    = running_reg;
        total_next      = total_reg;
        k_next          = k_reg;
        w_next          = w_reg;
        stop_idx_next   = stop_idx_reg;
        cur_idx_next    = cur_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;

        ord_we    = 1'b0;
        ord_waddr = w_reg[IDX_W-1:0];
        ord_wdata = ord_rdata;
        ord_re    = 1'b0;
        ord_raddr = k_plus[IDX_W-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = cur_idx_reg;
        cnt_wdata = dec;
        cnt_re    = 1'b0;
        cnt_raddr = ord_rdata;

        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.start && start_ok)
        begin
            cnt_we               = 1'b1;
            cnt_waddr            = in_idx;
            cnt_wdata            = count;
            running_next[in_idx] = 1'b1;
            // restart keeps its place in the order
            if (!running_reg[in_idx])
            begin
                ord_we     = 1'b1;
                ord_waddr  = total_reg[IDX_W-1:0];
                ord_wdata  = in_idx;
                total_next = total_reg + TOT_W'(1);
            end
        end

        if (cmd.stop_clear)
        begin
            running_next[in_idx] = 1'b0;
            stop_idx_next        = in_idx;
        end

        if (cmd.pass_init)
        begin
            k_next    = '0;
            w_next    = '0;
            ord_re    = 1'b1;
            ord_raddr = '0;
        end

        // compaction: read at k, write back at w, skip dropped entries
        if (cmd.stop_step)
        begin
            if (ord_rdata != stop_idx_reg)
            begin
                ord_we = 1'b1;
                w_next = w_reg + TOT_W'(1);
            end
            k_next = k_plus;
            ord_re = 1'b1;
        end

        if (cmd.count_read)
        begin
            cur_idx_next = ord_rdata;
            cnt_re       = 1'b1;
        end

        if (cmd.tick_step)
        begin
            cnt_we = 1'b1;
            if (expire)
            begin
                running_next[cur_idx_reg] = 1'b0;
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = ID_W'(pend_idx_reg);
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_idx_next   = cur_idx_reg;
            end
            else
            begin
                ord_we    = 1'b1;
                ord_wdata = cur_idx_reg;
                w_next    = w_reg + TOT_W'(1);
            end
            k_next = k_plus;
            ord_re = 1'b1;
        end

        if (cmd.finish)
        begin
            total_next = w_reg;
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_id_next     = ID_W'(pend_idx_reg);
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= '0;
            total_reg      <= '0;
            k_reg          <= '0;
            w_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            running_reg    <= running_next;
            total_reg      <= total_next;
            k_reg          <= k_next;
            w_reg          <= w_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stop_idx_reg <= stop_idx_next;
        cur_idx_reg  <= cur_idx_next;
        pend_idx_reg <= pend_idx_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign expired_id = out_id_reg;
    assign last       = out_last_reg;

    assign sts.id_ok      = id_ok;
    assign sts.id_running = running_reg[in_idx];
    assign sts.total_zero = (total_reg == '0);
    assign sts.pass_done  = (k_reg == total_reg);
    assign sts.expire     = expire;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

endmodule

>>> rtl/core/stb_checker.sv
// ----------------------------------------------------------------------------
// Timer bank checker
// Port-level properties of the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "software_timer_bank_macros.svh"

module stb_checker
    import stb_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [OP_W-1:0]  op,
    input logic             out_valid,
    input logic             out_stall,
    input logic [ID_W-1:0]  expired_id,
    input logic             last
);

    logic acc;

    assign acc = in_valid && !in_stall;

    `STB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(expired_id) && $stable(last), "held result changed")
    `STB_ASSERT_NEXT(a_start_one_cycle, acc && (op == OP_START),
        !in_stall, "start item did not finish in one cycle")
    `STB_ASSERT_NEXT(a_bad_op_one_cycle, acc && (op != OP_TICK) && (op != OP_START)
        && (op != OP_STOP), !in_stall, "unknown op held the input")
    `STB_ASSERT_NOW(a_busy_after_item, $rose(in_stall),
        $past(acc), "input stalled without an accepted item")
    `STB_ASSERT_NOW(a_result_in_pass, $rose(out_valid),
        $past(in_stall), "result appeared outside a pass")

endmodule

bind software_timer_bank stb_checker u_stb_checker (.*);
